// ===== design/wffm_pkg.sv =====
package wffm_pkg;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_FORCE    = 3'd0,
        REG_MIN      = 3'd1,
        REG_SPRING   = 3'd2,
        REG_DAMPING  = 3'd3,
        REG_FRICTION = 3'd4,
        REG_INVERT   = 3'd5
    } t_reg_idx;

    localparam int unsigned PCT_W   = 7;
    localparam int unsigned IN_W    = 16;
    localparam int unsigned DRIVE_W = 9;
    localparam int unsigned STAGES  = 7;

    localparam logic [8:0] DRIVE_LIMIT = 9'd255;

    // Reciprocals for exact floor division by constants
    // floor(x/100)   for x < 2^29 : (x * M) >> 36
    localparam logic [29:0] RECIP_100_A  = 30'd687194768;
    // floor(x/10000) for x < 2^22 : (x * M) >> 36
    localparam logic [22:0] RECIP_10000  = 23'd6871948;
    // floor(x/625)   for x < 2^31 : (x * M) >> 41
    localparam logic [31:0] RECIP_625    = 32'd3518437209;
    // floor(x/100)   for x < 2^31 : (x * M) >> 38
    localparam logic [31:0] RECIP_100_B  = 32'd2748779070;
    // floor(x/100)   for x < 2^15 : (x * M) >> 22
    localparam logic [15:0] RECIP_100_C  = 16'd41944;

    // 3*255/200000 reduced: 153/40000 = 153 / (64 * 625)
    localparam logic [7:0] DAMP_NUM = 8'd153;

    // Configuration registers
    typedef struct packed {
        logic [PCT_W-1:0] force_pct;
        logic [PCT_W-1:0] min_pct;
        logic [PCT_W-1:0] spring_pct;
        logic [PCT_W-1:0] damping_pct;
        logic [PCT_W-1:0] friction_pct;
        logic             invert;
    } t_cfg;

    // Pipeline control from the handshake logic
    typedef struct packed {
        logic en;
        logic in_vld;
    } t_pipe_ctl;

endpackage

// ===== design/wheel_force_feedback_mixer_top.sv =====
// Wheel force feedback mixer.
// Input channel (i_in_valid / o_in_ready) carries one request per sample:
// a signed wheel angle and a signed encoder velocity. Output channel
// (o_out_valid / i_out_ready) returns one signed drive value, -255..255,
// per request, in order. The drive mixes spring, damping and friction
// terms scaled by the gain registers, applies the minimum-force threshold,
// clamps to +-255 and optionally inverts.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
// (0 force, 1 min force, 2 spring, 3 damping, 4 friction, 5 invert);
// other indexes are ignored. Write only while no request is in flight.
// Throughput: one request per cycle while the output is not stalled, set
// by the seven-stage multiply/reciprocal pipeline.
// Receiver stall: the whole pipeline holds while the output stage is full
// and i_out_ready is low; o_in_ready then drops, nothing is lost.
// Reset (synchronous, active low): pipeline emptied, force 100 %, all
// other registers 0.
module wheel_force_feedback_mixer_top
    import wffm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [IN_W-1:0]     i_angle_deg,
    input  logic signed [IN_W-1:0]     i_velocity_counts,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [DRIVE_W-1:0]  o_drive,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [PCT_W-1:0]           i_cfg_wdata
);

    t_cfg      r_cfg;
    t_pipe_ctl w_ctl;
    logic      w_out_vld;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.force_pct    <= 7'd100;
            r_cfg.min_pct      <= '0;
            r_cfg.spring_pct   <= '0;
            r_cfg.damping_pct  <= '0;
            r_cfg.friction_pct <= '0;
            r_cfg.invert       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FORCE:    r_cfg.force_pct    <= i_cfg_wdata;
                REG_MIN:      r_cfg.min_pct      <= i_cfg_wdata;
                REG_SPRING:   r_cfg.spring_pct   <= i_cfg_wdata;
                REG_DAMPING:  r_cfg.damping_pct  <= i_cfg_wdata;
                REG_FRICTION: r_cfg.friction_pct <= i_cfg_wdata;
                REG_INVERT:   r_cfg.invert       <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless the output holds an untaken result
    assign w_ctl.en     = !w_out_vld || i_out_ready;
    assign w_ctl.in_vld = i_in_valid;
    assign o_in_ready   = w_ctl.en;
    assign o_out_valid  = w_out_vld;

    wffm_pipe u_pipe (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .i_cfg             (r_cfg),
        .i_angle_deg       (i_angle_deg),
        .i_velocity_counts (i_velocity_counts),
        .o_vld             (w_out_vld),
        .o_drive           (o_drive)
    );

endmodule

// ===== design/wffm_pipe.sv =====
module wffm_pipe
    import wffm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_pipe_ctl                  i_ctl,
    input  t_cfg                       i_cfg,
    input  logic signed [IN_W-1:0]     i_angle_deg,
    input  logic signed [IN_W-1:0]     i_velocity_counts,
    output logic                       o_vld,
    output logic signed [DRIVE_W-1:0]  o_drive
);

    logic [STAGES-1:0] r_vld;

    // stage 1: magnitudes, signs, gain products
    logic [15:0] r_s1_aabs, n_s1_aabs;
    logic [15:0] r_s1_vabs, n_s1_vabs;
    logic        r_s1_aneg, r_s1_vneg, r_s1_vnz;
    logic [13:0] r_s1_ks, n_s1_ks;
    logic [13:0] r_s1_kd, n_s1_kd;
    logic [13:0] r_s1_kf, n_s1_kf;
    // stage 2
    logic [28:0] r_s2_ms, n_s2_ms;
    logic [21:0] r_s2_kd153, n_s2_kd153;
    logic [21:0] r_s2_mf, n_s2_mf;
    logic [15:0] r_s2_vabs;
    logic        r_s2_aneg, r_s2_vneg, r_s2_vnz;
    // stage 3
    logic [22:0] r_s3_qs1, n_s3_qs1;
    logic [36:0] r_s3_md, n_s3_md;
    logic [8:0]  r_s3_qf, n_s3_qf;
    logic        r_s3_aneg, r_s3_vneg, r_s3_vnz;
    // stage 4
    logic [30:0] r_s4_ms2, n_s4_ms2;
    logic [20:0] r_s4_qd, n_s4_qd;
    logic [8:0]  r_s4_qf;
    logic        r_s4_aneg, r_s4_vneg, r_s4_vnz;
    // stage 5
    logic [23:0] r_s5_qs, n_s5_qs;
    logic [21:0] r_s5_dsum, n_s5_dsum;
    logic        r_s5_aneg, r_s5_vneg, r_s5_vnz;
    // stage 6
    logic signed [25:0] r_s6_total, n_s6_total;
    logic [8:0]  r_s6_minf, n_s6_minf;
    // stage 7 (output)
    logic signed [DRIVE_W-1:0] r_s7_drive, n_s7_drive;

    logic [58:0] w_p3s;
    logic [44:0] w_p3f;
    logic [62:0] w_p4d;
    logic [62:0] w_p5s;
    logic [14:0] w_mn255;
    logic [30:0] w_p6m;
    logic signed [25:0] w_ts, w_tv;
    logic [24:0] w_mag;
    logic [8:0]  w_lim;
    logic        w_neg;

    always_comb begin
        // stage 1
        n_s1_aabs = i_angle_deg[IN_W-1] ? 16'(-i_angle_deg) : 16'(i_angle_deg);
        n_s1_vabs = i_velocity_counts[IN_W-1] ? 16'(-i_velocity_counts)
                                              : 16'(i_velocity_counts);
        n_s1_ks = 14'(i_cfg.spring_pct) * 14'(i_cfg.force_pct);
        n_s1_kd = 14'(i_cfg.damping_pct) * 14'(i_cfg.force_pct);
        n_s1_kf = 14'(i_cfg.friction_pct) * 14'(i_cfg.force_pct);

        // stage 2
        n_s2_ms    = 29'(r_s1_aabs) * 29'(r_s1_ks);
        n_s2_kd153 = 22'(r_s1_kd) * 22'(DAMP_NUM);
        n_s2_mf    = 22'({r_s1_kf, 8'd0}) - 22'(r_s1_kf);

        // stage 3: spring /100, damping product, friction /10000
        w_p3s    = 59'(r_s2_ms) * 59'(RECIP_100_A);
        n_s3_qs1 = w_p3s[58:36];
        n_s3_md  = 37'(r_s2_vabs) * 37'(r_s2_kd153);
        w_p3f    = 45'(r_s2_mf) * 45'(RECIP_10000);
        n_s3_qf  = w_p3f[44:36];

        // stage 4: spring *255, damping /40000
        n_s4_ms2 = 31'({r_s3_qs1, 8'd0}) - 31'(r_s3_qs1);
        w_p4d    = 63'(r_s3_md[36:6]) * 63'(RECIP_625);
        n_s4_qd  = w_p4d[61:41];

        // stage 5: spring /100, velocity terms summed
        w_p5s     = 63'(r_s4_ms2) * 63'(RECIP_100_B);
        n_s5_qs   = w_p5s[61:38];
        n_s5_dsum = 22'(r_s4_qd) + 22'(r_s4_qf);

        // stage 6: signed total, minimum threshold
        w_ts = r_s5_aneg ? 26'(r_s5_qs) : -26'(r_s5_qs);
        if (!r_s5_vnz) begin
            w_tv = '0;
        end else if (r_s5_vneg) begin
            w_tv = 26'(r_s5_dsum);
        end else begin
            w_tv = -26'(r_s5_dsum);
        end
        n_s6_total = w_ts + w_tv;
        w_mn255    = 15'({i_cfg.min_pct, 8'd0}) - 15'(i_cfg.min_pct);
        w_p6m      = 31'(w_mn255) * 31'(RECIP_100_C);
        n_s6_minf  = w_p6m[30:22];

        // stage 7: threshold, clamp, invert
        w_neg = r_s6_total[25];
        w_mag = w_neg ? 25'(-r_s6_total) : 25'(r_s6_total);
        if (w_mag != '0 && w_mag < 25'(r_s6_minf)) begin
            w_mag = 25'(r_s6_minf);
        end
        if (w_mag > 25'(DRIVE_LIMIT)) begin
            w_lim = DRIVE_LIMIT;
        end else begin
            w_lim = w_mag[8:0];
        end
        n_s7_drive = (w_neg ^ i_cfg.invert) ? -$signed(w_lim) : $signed(w_lim);
    end

    // valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[STAGES-2:0], i_ctl.in_vld};
        end
    end

    // data registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_s1_aabs  <= n_s1_aabs;
            r_s1_vabs  <= n_s1_vabs;
            r_s1_aneg  <= i_angle_deg[IN_W-1];
            r_s1_vneg  <= i_velocity_counts[IN_W-1];
            r_s1_vnz   <= (i_velocity_counts != '0);
            r_s1_ks    <= n_s1_ks;
            r_s1_kd    <= n_s1_kd;
            r_s1_kf    <= n_s1_kf;

            r_s2_ms    <= n_s2_ms;
            r_s2_kd153 <= n_s2_kd153;
            r_s2_mf    <= n_s2_mf;
            r_s2_vabs  <= r_s1_vabs;
            r_s2_aneg  <= r_s1_aneg;
            r_s2_vneg  <= r_s1_vneg;
            r_s2_vnz   <= r_s1_vnz;

            r_s3_qs1   <= n_s3_qs1;
            r_s3_md    <= n_s3_md;
            r_s3_qf    <= n_s3_qf;
            r_s3_aneg  <= r_s2_aneg;
            r_s3_vneg  <= r_s2_vneg;
            r_s3_vnz   <= r_s2_vnz;

            r_s4_ms2   <= n_s4_ms2;
            r_s4_qd    <= n_s4_qd;
            r_s4_qf    <= r_s3_qf;
            r_s4_aneg  <= r_s3_aneg;
            r_s4_vneg  <= r_s3_vneg;
            r_s4_vnz   <= r_s3_vnz;

            r_s5_qs    <= n_s5_qs;
            r_s5_dsum  <= n_s5_dsum;
            r_s5_aneg  <= r_s4_aneg;
            r_s5_vneg  <= r_s4_vneg;
            r_s5_vnz   <= r_s4_vnz;

            r_s6_total <= n_s6_total;
            r_s6_minf  <= n_s6_minf;

            r_s7_drive <= n_s7_drive;
        end
    end

    assign o_vld   = r_vld[STAGES-1];
    assign o_drive = r_s7_drive;

endmodule

// ===== test/wffm_drive_checker.sv =====
`timescale 1ns / 100ps

// Watches the sample and drive channels of the mixer, predicts each drive
// value from its own copy of the gain registers and compares in order.
module wffm_drive_checker
    import wffm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic signed [IN_W-1:0]     i_angle_deg,
    input  logic signed [IN_W-1:0]     i_velocity_counts,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [DRIVE_W-1:0]  i_drive,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [PCT_W-1:0]           i_cfg_wdata,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);

    typedef struct {
        logic signed [IN_W-1:0]    angle;
        logic signed [IN_W-1:0]    velocity;
        logic signed [DRIVE_W-1:0] drive;
    } t_drive_exp;

    t_drive_exp drive_q[$];
    t_cfg       gains;
    int         mismatch_cnt;
    int         checked_cnt;

    // Spring + damping + friction mix, minimum-force lift, clamp, invert.
    // All divisions are signed, so they truncate toward zero.
    function automatic logic signed [DRIVE_W-1:0] mix_drive(
        input t_cfg                   c,
        input logic signed [IN_W-1:0] ang,
        input logic signed [IN_W-1:0] vel
    );
        longint f;
        longint a;
        longint v;
        longint total;
        longint fric;
        longint minf;
        f = longint'(c.force_pct);
        a = longint'(ang);
        v = longint'(vel);
        if (f == 0) begin
            return '0;
        end
        total = -(((a * longint'(c.spring_pct) * f) / 100) * 255 / 100);
        // Damping product stays below 2^39 in magnitude, so it fits a longint exactly
        total += -((v * 3 * longint'(c.damping_pct) * f * 255) / 200000);
        fric = (longint'(c.friction_pct) * f * 255) / 10000;
        if (v > 0) begin
            total -= fric;
        end else if (v < 0) begin
            total += fric;
        end
        minf = (longint'(c.min_pct) * 255) / 100;
        if (total > 0 && total < minf) begin
            total = minf;
        end
        if (total < 0 && total > -minf) begin
            total = -minf;
        end
        if (total > 255) begin
            total = 255;
        end
        if (total < -255) begin
            total = -255;
        end
        if (c.invert) begin
            total = -total;
        end
        return total[DRIVE_W-1:0];
    endfunction

    initial begin
        mismatch_cnt = 0;
        checked_cnt  = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin : watch
        t_drive_exp e;
        if (!i_rst_n) begin
            gains.force_pct    = 7'd100;
            gains.min_pct      = '0;
            gains.spring_pct   = '0;
            gains.damping_pct  = '0;
            gains.friction_pct = '0;
            gains.invert       = 1'b0;
            drive_q.delete();
        end else begin
            // Drive result: compare with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (drive_q.size() == 0) begin
                    $display("%0t: drive %0d arrived with no request pending",
                             $time, i_drive);
                    mismatch_cnt++;
                end else begin
                    e = drive_q.pop_front();
                    checked_cnt++;
                    if (i_drive !== e.drive) begin
                        $display({"%0t: drive mismatch (angle %0d, velocity %0d):",
                                  " expected %0d, actual %0d"},
                                 $time, e.angle, e.velocity, e.drive, i_drive);
                        mismatch_cnt++;
                    end
                end
            end
            // Accepted sample request: predict its drive
            if (i_in_valid && i_in_ready) begin
                e.angle    = i_angle_deg;
                e.velocity = i_velocity_counts;
                e.drive    = mix_drive(gains, i_angle_deg, i_velocity_counts);
                drive_q.push_back(e);
            end
            // Register writes; unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FORCE:    gains.force_pct    = i_cfg_wdata;
                    REG_MIN:      gains.min_pct      = i_cfg_wdata;
                    REG_SPRING:   gains.spring_pct   = i_cfg_wdata;
                    REG_DAMPING:  gains.damping_pct  = i_cfg_wdata;
                    REG_FRICTION: gains.friction_pct = i_cfg_wdata;
                    REG_INVERT:   gains.invert       = i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatch_cnt;
        o_pending    <= drive_q.size();
        o_checked    <= checked_cnt;
    end

endmodule

// ===== test/wheel_force_feedback_mixer_top_tb.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the force feedback mixer; the checker does the
// prediction and comparison.
module wheel_force_feedback_mixer_top_tb
    import wffm_pkg::*;
();

    localparam int         CYCLE_LIMIT   = 800000;
    localparam int         RAND_PHASES   = 14;
    localparam int         PHASE_ITEMS   = 118;
    localparam logic [2:0] SPARE_IDX_LO  = 3'd6;
    localparam logic [2:0] SPARE_IDX_HI  = 3'd7;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [IN_W-1:0]     angle;
    logic signed [IN_W-1:0]     velocity;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [DRIVE_W-1:0]  drive;
    logic                       cfg_we;
    logic [2:0]                 cfg_idx;
    logic [PCT_W-1:0]           cfg_wdata;

    int fail_count;
    int pending;
    int checked;
    int cycle_cnt;
    int setting_cnt;
    bit steady_run;   // no idling on either side

    wheel_force_feedback_mixer_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_angle_deg       (angle),
        .i_velocity_counts (velocity),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_drive           (drive),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_wdata       (cfg_wdata)
    );

    wffm_drive_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_angle_deg       (angle),
        .i_velocity_counts (velocity),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_drive           (drive),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_wdata       (cfg_wdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    // Clock, 2 ns period
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d drive results outstanding",
                     cycle_cnt, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: always ready in steady runs, else bursts of ready with mostly short, sometimes long stalls
    initial begin : drive_sink
        int run_len;
        int stall_len;
        out_ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (steady_run) begin
                out_ready = 1'b1;
                @(negedge i_clk);
            end else begin
                run_len = $urandom_range(1, 12);
                out_ready = 1'b1;
                repeat (run_len) @(negedge i_clk);
                stall_len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 50)
                                                          : $urandom_range(1, 3);
                out_ready = 1'b0;
                repeat (stall_len) @(negedge i_clk);
            end
        end
    end

    function automatic t_cfg make_cfg(
        input logic [PCT_W-1:0] f,
        input logic [PCT_W-1:0] m,
        input logic [PCT_W-1:0] s,
        input logic [PCT_W-1:0] d,
        input logic [PCT_W-1:0] fr,
        input logic             inv
    );
        t_cfg c;
        c.force_pct    = f;
        c.min_pct      = m;
        c.spring_pct   = s;
        c.damping_pct  = d;
        c.friction_pct = fr;
        c.invert       = inv;
        return c;
    endfunction

    // Gain: weighted toward 0, 100 and the 7-bit maximum
    function automatic logic [PCT_W-1:0] rand_pct();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 7'd0;
            1:       return 7'd127;
            2:       return 7'd100;
            default: return PCT_W'($urandom_range(0, 100));
        endcase
    endfunction

    // Angle or velocity: mostly small so the terms stay out of the clamp
    function automatic logic signed [IN_W-1:0] rand_field();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return IN_W'($urandom_range(0, 16) - 8);
        end else if (r < 6) begin
            return IN_W'($urandom_range(0, 600) - 300);
        end else if (r == 6) begin
            case ($urandom_range(0, 4))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sd1;
                3:       return -16'sd1;
                default: return 16'sd0;
            endcase
        end
        return IN_W'($urandom);
    endfunction

    // All register tasks start and end on a falling edge
    task automatic write_reg(input logic [2:0] idx, input logic [PCT_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    task automatic apply_cfg(input t_cfg c);
        logic [PCT_W-2:0] junk;
        junk = ($urandom_range(0, 1) == 0) ? '0 : (PCT_W-1)'($urandom);
        write_reg(REG_FORCE,    c.force_pct);
        write_reg(REG_MIN,      c.min_pct);
        write_reg(REG_SPRING,   c.spring_pct);
        write_reg(REG_DAMPING,  c.damping_pct);
        write_reg(REG_FRICTION, c.friction_pct);
        // upper data bits are don't-care for the invert flag
        write_reg(REG_INVERT,   {junk, c.invert});
        setting_cnt++;
    endtask

    // One sample request, with a random idle gap in front unless steady
    task automatic send_sample(input logic signed [IN_W-1:0] a,
                               input logic signed [IN_W-1:0] v);
        int r;
        int gap;
        gap = 0;
        if (!steady_run) begin
            r = $urandom_range(0, 99);
            if (r < 60)      gap = 0;
            else if (r < 90) gap = $urandom_range(1, 3);
            else if (r < 98) gap = $urandom_range(4, 10);
            else             gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        angle    = a;
        velocity = v;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    // Wait for every drive to come back, then let the pipeline empty
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (STAGES + 3) @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_cfg c;
        in_valid    = 1'b0;
        angle       = '0;
        velocity    = '0;
        cfg_we      = 1'b0;
        cfg_idx     = '0;
        cfg_wdata   = '0;
        steady_run  = 1'b0;
        setting_cnt = 0;
        i_rst_n     = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset gains: spring, damping and friction are off
        send_sample(16'sd12345, -16'sd321);
        send_sample(16'sd0, 16'sd0);
        // Writes to indexes past the last register change nothing
        drain();
        write_reg(SPARE_IDX_LO, 7'h55);
        write_reg(SPARE_IDX_HI, 7'h7F);
        send_sample(16'sd100, 16'sd10);

        // All gains at 100: field extremes and unit steps
        drain();
        apply_cfg(make_cfg(7'd100, 7'd0, 7'd100, 7'd100, 7'd100, 1'b0));
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd0);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd1);
        send_sample(16'sd0, -16'sd1);
        send_sample(16'sh7FFF, 16'sd0);
        send_sample(16'sh8000, 16'sd0);
        send_sample(16'sd0, 16'sh7FFF);
        send_sample(16'sd0, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);

        // Minimum above full scale, inverted: lifted then clamped
        drain();
        apply_cfg(make_cfg(7'd127, 7'd127, 7'd1, 7'd1, 7'd0, 1'b1));
        write_reg(REG_INVERT, 7'h7F);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd0);
        send_sample(-16'sd3, 16'sd2);

        // Zero overall force silences everything
        drain();
        apply_cfg(make_cfg(7'd0, 7'd127, 7'd127, 7'd127, 7'd127, 1'b0));
        write_reg(REG_INVERT, 7'h7E);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(-16'sd5, -16'sd5);

        // Friction alone, lifted by the minimum; zero velocity stays zero
        drain();
        apply_cfg(make_cfg(7'd100, 7'd10, 7'd0, 7'd0, 7'd1, 1'b0));
        send_sample(16'sd0, 16'sd5);
        send_sample(16'sd0, -16'sd5);
        send_sample(16'sd0, 16'sd0);

        // Random phases: a few fixed corner settings, then random gains
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            case (p)
                0:       c = make_cfg(7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 1'b1);
                1:       c = make_cfg(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
                2:       c = make_cfg(7'd100, 7'd0, 7'd100, 7'd100, 7'd100, 1'b0);
                3:       c = make_cfg(7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 1'b1);
                default: c = make_cfg(rand_pct(), rand_pct(), rand_pct(), rand_pct(),
                                      rand_pct(), 1'($urandom));
            endcase
            apply_cfg(c);
            steady_run = (p % 4 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_sample(rand_field(), rand_field());
            end
            in_valid = 1'b0;
        end
        steady_run = 1'b0;

        drain();
        $display("Covered %0d drive results over %0d gain settings,",
                 checked, setting_cnt);
        $display("small to full-scale inputs, random request gaps and drive stalls,");
        $display("plus back-to-back stretches.");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
